// File: rtl/lzwd_pkg.sv
// Shared types and constants for the LZSS window decompressor.
// Used by the front end, command queue, back end and top level.
package lzwd_pkg;

  localparam int WINDOW_BYTES_DEF = 4096;
  localparam int CNT_W            = 20;
  localparam int POS_W            = 13;
  localparam int LEN_W            = 5;
  localparam int Q_DEPTH          = 4;
  localparam int Q_AW             = $clog2(Q_DEPTH);

  localparam logic [2:0]       HEADER_BYTES = 3'd4;
  localparam logic [3:0]       FLAG_BITS    = 4'd8;
  localparam logic [POS_W-1:0] POS_BIAS     = POS_W'(18);
  localparam logic [LEN_W-1:0] LEN_BIAS     = LEN_W'(3);
  localparam logic [CNT_W-1:0] LIMIT_RESET  = CNT_W'(64000);

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_ITEM,
    PH_PAIR
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LIT,
    CMD_COPY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [7:0]            lit;
    logic [POS_W-1:0]      pos;
    logic [LEN_W-1:0]      len;
    logic [CNT_W-1:0]      base;
    logic                  done;
    logic                  err;
  } cmd_t;

endpackage

// File: rtl/lzwd_front.sv
// Front end: parses the compressed byte stream into literal/copy/none commands.
// Holds the block state and the output limit register; uses lzwd_pkg.
module lzwd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_byte,
  input  logic                        in_last,
  input  logic                        cfg_wr_en,
  input  logic [lzwd_pkg::CNT_W-1:0]  cfg_wr_data,
  input  logic                        cmd_ready,
  output logic                        cmd_push,
  output lzwd_pkg::cmd_t              cmd
);

  logic [lzwd_pkg::CNT_W-1:0] limit_r;
  logic [lzwd_pkg::CNT_W-1:0] oc_r, oc_nxt;
  logic [7:0]                 flag_r, flag_nxt;
  logic [3:0]                 left_r, left_nxt;
  lzwd_pkg::phase_t           phase_r, phase_nxt;
  logic [7:0]                 first_r, first_nxt;
  logic [2:0]                 hdr_r, hdr_nxt;
  logic                       stop_r, stop_nxt;
  logic                       err_r, err_nxt;

  logic                       accept;
  logic [11:0]                p12;
  logic [lzwd_pkg::POS_W-1:0] pos;
  logic [lzwd_pkg::LEN_W-1:0] len, len_eff;
  logic [lzwd_pkg::CNT_W-1:0] rem;
  logic                       bad_pos;
  logic [3:0]                 left_dec;

  assign in_tready = cmd_ready;
  assign accept    = in_tvalid && cmd_ready;
  assign cmd_push  = accept;

  assign p12     = {in_byte[7:4], first_r};
  assign pos     = {p12[11], p12} + lzwd_pkg::POS_BIAS;
  assign bad_pos = !pos[lzwd_pkg::POS_W-1] &&
                   ({{(lzwd_pkg::CNT_W-lzwd_pkg::POS_W+1){1'b0}},
                     pos[lzwd_pkg::POS_W-2:0]} > oc_r);
  assign len     = lzwd_pkg::LEN_W'(in_byte[3:0]) + lzwd_pkg::LEN_BIAS;
  assign rem     = limit_r - oc_r;
  assign len_eff = (oc_r >= limit_r) ? '0 :
                   ((rem < lzwd_pkg::CNT_W'(len)) ? rem[lzwd_pkg::LEN_W-1:0] : len);
  assign left_dec = (left_r != 4'd0) ? left_r - 4'd1 : 4'd0;

  always_comb begin
    oc_nxt    = oc_r;
    flag_nxt  = flag_r;
    left_nxt  = left_r;
    phase_nxt = phase_r;
    first_nxt = first_r;
    hdr_nxt   = hdr_r;
    stop_nxt  = stop_r;
    err_nxt   = err_r;
    cmd.kind  = lzwd_pkg::CMD_NONE;
    cmd.lit   = in_byte;
    cmd.pos   = pos;
    cmd.len   = len_eff;
    cmd.base  = oc_r;
    if (!stop_r) begin
      if (hdr_r != 3'd0) begin
        hdr_nxt = hdr_r - 3'd1;
      end else if (phase_r != lzwd_pkg::PH_PAIR && oc_r >= limit_r) begin
        stop_nxt = 1'b1;
      end else begin
        case (phase_r)
          lzwd_pkg::PH_FLAG: begin
            flag_nxt  = in_byte;
            left_nxt  = lzwd_pkg::FLAG_BITS;
            phase_nxt = lzwd_pkg::PH_ITEM;
          end
          lzwd_pkg::PH_ITEM: begin
            if (flag_r[0]) begin
              cmd.kind  = lzwd_pkg::CMD_LIT;
              oc_nxt    = oc_r + 1'b1;
              flag_nxt  = flag_r >> 1;
              left_nxt  = left_dec;
              phase_nxt = (left_dec != 4'd0) ? lzwd_pkg::PH_ITEM : lzwd_pkg::PH_FLAG;
              stop_nxt  = (oc_r + 1'b1) >= limit_r;
            end else begin
              first_nxt = in_byte;
              phase_nxt = lzwd_pkg::PH_PAIR;
            end
          end
          lzwd_pkg::PH_PAIR: begin
            if (bad_pos) begin
              err_nxt  = 1'b1;
              stop_nxt = 1'b1;
            end else begin
              if (len_eff != '0) cmd.kind = lzwd_pkg::CMD_COPY;
              oc_nxt    = oc_r + lzwd_pkg::CNT_W'(len_eff);
              flag_nxt  = flag_r >> 1;
              left_nxt  = left_dec;
              phase_nxt = (left_dec != 4'd0) ? lzwd_pkg::PH_ITEM : lzwd_pkg::PH_FLAG;
              stop_nxt  = (oc_r + lzwd_pkg::CNT_W'(len_eff)) >= limit_r;
            end
          end
          default: begin
            phase_nxt = lzwd_pkg::PH_FLAG;
          end
        endcase
      end
    end
    cmd.done = stop_nxt || in_last;
    cmd.err  = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= lzwd_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oc_r    <= '0;
      flag_r  <= '0;
      left_r  <= '0;
      phase_r <= lzwd_pkg::PH_FLAG;
      first_r <= '0;
      hdr_r   <= lzwd_pkg::HEADER_BYTES;
      stop_r  <= 1'b0;
      err_r   <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        oc_r    <= '0;
        flag_r  <= '0;
        left_r  <= '0;
        phase_r <= lzwd_pkg::PH_FLAG;
        first_r <= '0;
        hdr_r   <= lzwd_pkg::HEADER_BYTES;
        stop_r  <= 1'b0;
        err_r   <= 1'b0;
      end else begin
        oc_r    <= oc_nxt;
        flag_r  <= flag_nxt;
        left_r  <= left_nxt;
        phase_r <= phase_nxt;
        first_r <= first_nxt;
        hdr_r   <= hdr_nxt;
        stop_r  <= stop_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

// File: rtl/lzwd_cmd_queue.sv
// Short command queue between the parsing front end and the copy back end.
// Uses lzwd_pkg for the command type and depth.
module lzwd_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lzwd_pkg::cmd_t push_cmd,
  output logic           push_ready,
  output logic           pop_valid,
  output lzwd_pkg::cmd_t pop_cmd,
  input  logic           pop
);

  lzwd_pkg::cmd_t             q_r [lzwd_pkg::Q_DEPTH];
  logic [lzwd_pkg::Q_AW-1:0]  wp_r, rp_r;
  logic [lzwd_pkg::Q_AW:0]    cnt_r, cnt_nxt;

  assign push_ready = cnt_r != (lzwd_pkg::Q_AW+1)'(lzwd_pkg::Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_cmd;
  end

endmodule

// File: rtl/lzwd_back.sv
// Back end: executes commands against the ring window, one result per cycle unless stalled.
// Holds the window memory, read bypass and output register; uses lzwd_pkg.
module lzwd_back #(
  parameter int WINDOW_BYTES = lzwd_pkg::WINDOW_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  lzwd_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_byte,
  output logic           out_has,
  output logic           out_last,
  output logic           out_done,
  output logic           out_err
);

  localparam int AW = $clog2(WINDOW_BYTES);

  logic [7:0] mem [WINDOW_BYTES];

  logic                        a_busy_r, a_busy_nxt;
  lzwd_pkg::cmd_kind_t         a_kind_r;
  logic [7:0]                  a_lit_r;
  logic [AW-1:0]               a_slot_r;
  logic [lzwd_pkg::CNT_W-1:0]  a_cnt_r;
  logic [lzwd_pkg::LEN_W-1:0]  a_left_r;
  logic                        a_done_r, a_err_r;

  logic                        b_valid_r;
  logic                        b_has_r, b_lit_r, b_zero_r, b_hit_r, b_wr_r, b_last_r;
  logic                        b_done_r, b_err_r;
  logic [7:0]                  b_byte_r;
  logic [AW-1:0]               b_waddr_r;
  logic [7:0]                  fwd_r, rd_data_r;

  logic                        o_valid_r;
  logic [7:0]                  o_byte_r;
  logic                        o_has_r, o_last_r, o_done_r, o_err_r;

  logic                        adv, a_copy, a_last, a_zero, load, hit;
  logic [7:0]                  b_value;

  assign adv    = !b_valid_r || !o_valid_r || out_tready;
  assign a_copy = a_kind_r == lzwd_pkg::CMD_COPY;
  assign a_last = !a_copy || (a_left_r == lzwd_pkg::LEN_W'(1));
  assign a_zero = a_copy && (a_cnt_r < lzwd_pkg::CNT_W'(WINDOW_BYTES)) &&
                  (a_slot_r >= a_cnt_r[AW-1:0]);
  assign load   = cmd_valid && (!a_busy_r || (adv && a_last));
  assign hit    = b_valid_r && b_wr_r && (b_waddr_r == a_slot_r);
  assign cmd_pop = load;

  always_comb begin
    if (b_lit_r)       b_value = b_byte_r;
    else if (b_zero_r) b_value = 8'd0;
    else if (b_hit_r)  b_value = fwd_r;
    else               b_value = rd_data_r;
    if (!b_has_r)      b_value = 8'd0;
  end

  always_comb begin
    a_busy_nxt = a_busy_r;
    if (adv && a_busy_r && a_last) a_busy_nxt = 1'b0;
    if (load) a_busy_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_busy_r  <= 1'b0;
      b_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      a_busy_r <= a_busy_nxt;
      if (adv) b_valid_r <= a_busy_r;
      if (adv && b_valid_r) o_valid_r <= 1'b1;
      else if (out_tready)  o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_kind_r <= cmd.kind;
      a_lit_r  <= cmd.lit;
      a_slot_r <= cmd.pos[AW-1:0];
      a_cnt_r  <= cmd.base;
      a_left_r <= cmd.len;
      a_done_r <= cmd.done;
      a_err_r  <= cmd.err;
    end else if (adv && a_busy_r && a_copy) begin
      a_slot_r <= a_slot_r + 1'b1;
      a_cnt_r  <= a_cnt_r + 1'b1;
      a_left_r <= a_left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_has_r   <= a_kind_r != lzwd_pkg::CMD_NONE;
      b_lit_r   <= a_kind_r == lzwd_pkg::CMD_LIT;
      b_byte_r  <= a_lit_r;
      b_zero_r  <= a_zero;
      b_hit_r   <= hit;
      b_wr_r    <= a_kind_r != lzwd_pkg::CMD_NONE;
      b_waddr_r <= a_cnt_r[AW-1:0];
      b_last_r  <= a_last;
      b_done_r  <= a_done_r;
      b_err_r   <= a_err_r;
      fwd_r     <= b_value;
    end
    if (adv && b_valid_r) begin
      o_byte_r <= b_value;
      o_has_r  <= b_has_r;
      o_last_r <= b_last_r;
      o_done_r <= b_done_r;
      o_err_r  <= b_err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) rd_data_r <= mem[a_slot_r];
  end

  always_ff @(posedge clk) begin
    if (adv && b_valid_r && b_wr_r) mem[b_waddr_r] <= b_value;
  end

  assign out_tvalid = o_valid_r;
  assign out_byte   = o_byte_r;
  assign out_has    = o_has_r;
  assign out_last   = o_last_r;
  assign out_done   = o_done_r;
  assign out_err    = o_err_r;

endmodule

// File: rtl/lzss_window_decompressor_core.sv
// LZSS decompressor with a ring window: input bytes are taken at up to one per
// cycle while the 4-entry command queue has room; the back end emits one result
// per cycle, unless the output stalls, through its single window read port, so a
// literal, header, flag or first pair byte yields one result and a copy yields one
// result per byte it produces (at most 18, fewer when cut at the output limit), or
// a single empty result when the limit or a bad position leaves it empty. The window
// needs no clearing pass after reset: positions not yet written in the current
// block are forced to zero by count comparison.
// Depends on lzwd_pkg, lzwd_front, lzwd_cmd_queue and lzwd_back.
module lzss_window_decompressor_core #(
  parameter int WINDOW_BYTES = lzwd_pkg::WINDOW_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,    // [7:0] in_byte
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,   // [7:0] out_byte
  output logic [2:0]                  out_tuser,   // [0] has_data [1] block_done [2] error
  output logic                        out_tlast,
  input  logic                        cfg_wr_en,
  input  logic [lzwd_pkg::CNT_W-1:0]  cfg_wr_data
);

  lzwd_pkg::cmd_t f_cmd, q_cmd;
  logic           f_push, q_ready, q_valid, q_pop;
  logic           o_has, o_done, o_err;

  lzwd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_byte     (in_tdata),
    .in_last     (in_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_ready   (q_ready),
    .cmd_push    (f_push),
    .cmd         (f_cmd)
  );

  lzwd_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_cmd   (f_cmd),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop        (q_pop)
  );

  lzwd_back #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd        (q_cmd),
    .cmd_pop    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_has    (o_has),
    .out_last   (out_tlast),
    .out_done   (o_done),
    .out_err    (o_err)
  );

  assign out_tuser = {o_err, o_done, o_has};

endmodule

// File: bench/lzwd_decode_check.sv
`timescale 1ns / 1ps
// Decode checker for lzss_window_decompressor_core: watches the request, result and
// config ports, decodes every accepted byte itself and compares the result stream.
// Depends on lzwd_pkg.
module lzwd_decode_check (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [7:0]                 in_tdata,    // [7:0] in_byte
  input  logic                       in_tlast,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [7:0]                 out_tdata,   // [7:0] out_byte
  input  logic [2:0]                 out_tuser,   // [0] has_data [1] block_done [2] error
  input  logic                       out_tlast,
  input  logic                       cfg_wr_en,
  input  logic [lzwd_pkg::CNT_W-1:0] cfg_wr_data,
  output int                         mismatches,
  output int                         decoded_pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       run_last;
    logic       done;
    logic       err;
  } decoded_t;

  decoded_t                   decoded_q[$];
  logic [7:0]                 made_bytes[$];
  logic [7:0]                 win[lzwd_pkg::WINDOW_BYTES_DEF];
  logic [lzwd_pkg::CNT_W-1:0] limit;
  logic [lzwd_pkg::CNT_W-1:0] produced;
  logic [7:0]                 flags;
  logic [3:0]                 flags_left;
  lzwd_pkg::phase_t           ph;
  logic [7:0]                 pair_lo;
  logic [2:0]                 skip_left;
  logic                       halted;
  logic                       failed;
  int                         fail_n;

  function automatic void start_block();
    produced   = '0;
    flags      = '0;
    flags_left = '0;
    ph         = lzwd_pkg::PH_FLAG;
    pair_lo    = '0;
    skip_left  = lzwd_pkg::HEADER_BYTES;
    halted     = 1'b0;
    failed     = 1'b0;
  endfunction

  function automatic void emit(logic [7:0] v);
    win[produced[11:0]] = v;
    produced++;
    made_bytes.push_back(v);
  endfunction

  function automatic void close_item();
    flags = flags >> 1;
    if (flags_left != 0) flags_left--;
    ph = (flags_left != 0) ? lzwd_pkg::PH_ITEM : lzwd_pkg::PH_FLAG;
    if (produced >= limit) halted = 1'b1;
  endfunction

  function automatic void take(logic [7:0] b);
    int pos;
    int len;
    int slot;
    int k;
    logic [7:0] v;
    if (skip_left != 0) begin
      skip_left--;
      return;
    end
    if (ph != lzwd_pkg::PH_PAIR && produced >= limit) begin
      halted = 1'b1;
      return;
    end
    case (ph)
      lzwd_pkg::PH_FLAG: begin
        flags      = b;
        flags_left = lzwd_pkg::FLAG_BITS;
        ph         = lzwd_pkg::PH_ITEM;
      end
      lzwd_pkg::PH_ITEM: begin
        if (flags[0]) begin
          emit(b);
          close_item();
        end else begin
          pair_lo = b;
          ph      = lzwd_pkg::PH_PAIR;
        end
      end
      default: begin
        pos = $signed({b[7:4], pair_lo}) + 18;
        len = int'(b[3:0]) + 3;
        if (pos > int'(produced)) begin
          failed = 1'b1;
          halted = 1'b1;
          return;
        end
        for (k = 0; k < len && produced < limit; k++) begin
          slot = (pos + k) & (lzwd_pkg::WINDOW_BYTES_DEF - 1);
          // slots not yet written in this block read as zero
          if (int'(produced) < lzwd_pkg::WINDOW_BYTES_DEF && slot >= int'(produced))
            v = 8'h00;
          else v = win[slot];
          emit(v);
        end
        close_item();
      end
    endcase
  endfunction

  function automatic void decode_in_byte(logic [7:0] b, logic last);
    decoded_t r;
    int n;
    made_bytes.delete();
    if (!halted) take(b);
    n = made_bytes.size();
    r.done = halted | last;
    r.err  = failed;
    if (n == 0) begin
      r.data     = 8'h00;
      r.has_data = 1'b0;
      r.run_last = 1'b1;
      decoded_q.push_back(r);
    end
    for (int i = 0; i < n; i++) begin
      r.data     = made_bytes[i];
      r.has_data = 1'b1;
      r.run_last = (i == n - 1);
      decoded_q.push_back(r);
    end
    if (last) start_block();
  endfunction

  always @(posedge clk) begin : watch
    decoded_t want;
    if (!rst_n) begin
      limit = lzwd_pkg::LIMIT_RESET;
      foreach (win[i]) win[i] = 8'h00;
      start_block();
      decoded_q.delete();
      fail_n = 0;
    end else begin
      if (cfg_wr_en) limit = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: out_byte %0h", out_tdata);
          fail_n++;
        end else begin
          want = decoded_q.pop_front();
          if (want.data !== out_tdata) begin
            $error("out_byte: expected %0h, got %0h", want.data, out_tdata);
            fail_n++;
          end
          if (want.has_data !== out_tuser[0]) begin
            $error("has_data: expected %0b, got %0b", want.has_data, out_tuser[0]);
            fail_n++;
          end
          if (want.done !== out_tuser[1]) begin
            $error("block_done: expected %0b, got %0b", want.done, out_tuser[1]);
            fail_n++;
          end
          if (want.err !== out_tuser[2]) begin
            $error("error: expected %0b, got %0b", want.err, out_tuser[2]);
            fail_n++;
          end
          if (want.run_last !== out_tlast) begin
            $error("run_last: expected %0b, got %0b", want.run_last, out_tlast);
            fail_n++;
          end
        end
      end
      if (in_tvalid && in_tready) decode_in_byte(in_tdata, in_tlast);
    end
    mismatches      <= fail_n;
    decoded_pending <= decoded_q.size();
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the bench for lzss_window_decompressor_core: clock, reset, compressed
// block stimulus, config writes and verdict. Depends on lzwd_pkg, lzwd_decode_check.
module tb_top;

  localparam int LONG_HOLD    = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } in_req_t;

  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       in_tvalid   = 1'b0;
  logic                       in_tready;
  logic [7:0]                 in_tdata    = 8'h00;
  logic                       in_tlast    = 1'b0;
  logic                       out_tvalid;
  logic                       out_tready  = 1'b0;
  logic [7:0]                 out_tdata;
  logic [2:0]                 out_tuser;
  logic                       out_tlast;
  logic                       cfg_wr_en   = 1'b0;
  logic [lzwd_pkg::CNT_W-1:0] cfg_wr_data = '0;

  int      mismatches;
  int      decoded_pending;
  int      idle_cycles = 0;
  bit      no_gaps     = 1'b0;
  bit      hold_req    = 1'b0;
  in_req_t req_q[$];

  lzss_window_decompressor_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  lzwd_decode_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatches      (mismatches),
    .decoded_pending (decoded_pending)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_req(logic [7:0] b, logic last);
    in_req_t r;
    r.data = b;
    r.last = last;
    req_q.push_back(r);
  endfunction

  // pos is the absolute position (-2030..2065), len is 3..18
  function automatic void push_pair(int pos, int len);
    logic [11:0] code;
    code = 12'(pos - 18);
    push_req(code[7:0], 1'b0);
    push_req({code[11:8], 4'(len - 3)}, 1'b0);
  endfunction

  // well-formed block: header, flag bytes, literals and valid copies, rarely a bad one
  function automatic void gen_block(int n_items, bit long_mode);
    int made;
    int left;
    int hi;
    int pos;
    int len;
    logic [7:0] flag;
    for (int i = 0; i < 4; i++) push_req(8'($urandom), 1'b0);
    made = 0;
    left = n_items;
    while (left > 0) begin
      flag = long_mode ? 8'h00 : 8'($urandom);
      push_req(flag, 1'b0);
      for (int b = 0; b < 8 && left > 0; b++) begin
        left--;
        if (flag[b]) begin
          push_req(8'($urandom), 1'b0);
          made++;
        end else begin
          hi  = (made < 2065) ? made : 2065;
          len = long_mode ? 18 : int'($urandom_range(3, 18));
          if (!long_mode && hi < 2065 && $urandom_range(0, 39) == 0)
            pos = int'($urandom_range(hi + 1, 2065));
          else if ($urandom_range(0, 1) == 0)
            pos = hi - int'($urandom_range(0, 40));
          else
            pos = -2030 + int'($urandom_range(0, hi + 2030));
          made += len;
          push_pair(pos, len);
        end
      end
    end
    req_q[req_q.size() - 1].last = 1'b1;
  endfunction

  task automatic send_reqs(int n);
    in_req_t r;
    int gap;
    repeat (n) begin
      r = req_q.pop_front();
      in_tdata  <= r.data;
      in_tlast  <= r.last;
      in_tvalid <= 1'b1;
      do @(posedge clk); while (!in_tready);
      gap = pick_gap();
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic set_limit(int v);
    do @(posedge clk); while (decoded_pending != 0);
    cfg_wr_data <= lzwd_pkg::CNT_W'(v);
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // result side: short bursts and gaps, one long hold on request
  initial begin : sink
    int burst;
    int gap;
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= 1'b1;
        burst = $urandom_range(1, 12);
        repeat (burst) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim
    int limits[5];
    int phase_items;
    int kind;
    int cut;
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // literals at both extremes, copy at the output count, most negative copy,
    // longest copy, bad position, then an ignored request ending the block
    push_req(8'h00, 1'b0);
    push_req(8'hFF, 1'b0);
    push_req(8'h00, 1'b0);
    push_req(8'hFF, 1'b0);
    push_req(8'h03, 1'b0);
    push_req(8'h00, 1'b0);
    push_req(8'hFF, 1'b0);
    push_pair(2, 3);
    push_pair(-2030, 18);
    push_pair(0, 18);
    push_pair(2065, 3);
    push_req(8'h5A, 1'b1);
    // block cut in the header
    push_req(8'h81, 1'b1);
    // block cut on the first byte of a pair
    for (int i = 0; i < 4; i++) push_req(8'($urandom), 1'b0);
    push_req(8'h00, 1'b0);
    push_req(8'h7E, 1'b1);
    send_reqs(req_q.size());

    limits = '{1, int'($urandom_range(2, 40)), 64000, 1048575,
               int'($urandom_range(100, 3000))};
    for (int p = 0; p < 5; p++) begin
      set_limit(limits[p]);
      no_gaps = (p == 2) || ($urandom_range(0, 3) == 0);
      phase_items = 0;
      while (phase_items < 12) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          n = $urandom_range(1, 12);
          for (int j = 0; j < n; j++) push_req(8'($urandom), j == n - 1);
        end else begin
          gen_block($urandom_range(2, 12), 1'b0);
          if (kind == 1) begin
            cut = $urandom_range(0, req_q.size() - 1);
            while (req_q.size() > cut + 1) void'(req_q.pop_back());
            req_q[cut].last = 1'b1;
          end else if (kind == 2) begin
            req_q[req_q.size() - 1].last = 1'b0;
            n = $urandom_range(1, 4);
            for (int j = 0; j < n; j++) push_req(8'($urandom), j == n - 1);
          end
        end
        phase_items += req_q.size();
        send_reqs(req_q.size());
      end
    end
    no_gaps = 1'b0;

    // limit lowered below the output count in the middle of a block
    set_limit(1048575);
    gen_block(16, 1'b0);
    send_reqs(req_q.size() / 2);
    set_limit($urandom_range(1, 8));
    send_reqs(req_q.size());

    // long copies, with the result side held off at first
    set_limit(1048575);
    hold_req = 1'b1;
    gen_block(30, 1'b1);
    send_reqs(req_q.size());

    do @(posedge clk); while (decoded_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
